// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the byte mix hash RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/flbmh_pkg.sv
// ----------------------------------------------------------------------------
// flbmh_pkg
// Types, constants and the mixing round of the four lane byte mix hash.
// ----------------------------------------------------------------------------
package flbmh_pkg;

    localparam int DATA_W      = 8;
    localparam int DIGEST_W    = 64;
    localparam int N_WORDS     = 4;
    localparam int OUT_WORDS   = 8;
    localparam int OUT_SAMPLES = 32;
    localparam int SMP_IDX_W   = 5;
    localparam int QUEUE_DEPTH = 4;

    localparam int BLOCK_BYTES_DEF   = 64;
    localparam int SAMPLE_SLOTS_DEF  = 32;
    localparam int SAMPLE_STRIDE_DEF = 6;

    localparam logic [5:0] ROT_0 = 6'd3;
    localparam logic [5:0] ROT_1 = 6'd5;
    localparam logic [5:0] ROT_2 = 6'd7;
    localparam logic [5:0] ROT_3 = 6'd11;

    typedef logic [N_WORDS-1:0][DIGEST_W-1:0] t_words;

    localparam t_words SEEDS = {
        64'ha54ff53a5f1d36f1,
        64'h3c6ef372fe94f82b,
        64'hbb67ae8584caa73b,
        64'h6a09e667f3bcc908
    };

    function automatic int pos_width(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    function automatic int entry_width(input int pos_w);
        return DATA_W + 2 + 2 * pos_w + 1 + SMP_IDX_W;
    endfunction

    function automatic logic [DIGEST_W-1:0] rotr64(input logic [DIGEST_W-1:0] v,
                                                   input logic [5:0] r);
        logic [6:0] l;
        l = 7'd64 - {1'b0, r};
        return (v >> r) | (v << l);
    endfunction

    function automatic t_words mix_round(input t_words w, input logic [DATA_W-1:0] b);
        logic [DIGEST_W-1:0] bx;
        t_words n;
        bx   = {{(DIGEST_W-DATA_W){1'b0}}, b};
        n[0] = (w[0] + bx) ^ w[1];
        n[1] = (w[1] + bx) ^ w[2];
        n[2] = (w[2] + bx) ^ w[3];
        n[3] = (w[3] + bx) ^ n[0];
        n[0] = rotr64(n[0], ROT_0);
        n[1] = rotr64(n[1], ROT_1);
        n[2] = rotr64(n[2], ROT_2);
        n[3] = rotr64(n[3], ROT_3);
        return n;
    endfunction

endpackage

// File: src/flbmh_if.sv
// ----------------------------------------------------------------------------
// flbmh_if
// Valid/ready channels: message item input and digest word output.
// ----------------------------------------------------------------------------
interface flbmh_item_if import flbmh_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_byte;
    logic              has_byte;
    logic              end_of_message;

    modport source (output valid, output data_byte, output has_byte,
                    output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input has_byte,
                    input end_of_message, output ready);
endinterface

interface flbmh_digest_if import flbmh_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [DIGEST_W-1:0] digest_word;
    logic                last_word;

    modport source (output valid, output digest_word, output last_word, input ready);
    modport sink   (input valid, input digest_word, input last_word, output ready);
endinterface

// File: src/flbmh_ram.sv
// ----------------------------------------------------------------------------
// flbmh_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module flbmh_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/flbmh_front.sv
// ----------------------------------------------------------------------------
// flbmh_front
// Accepts message items, tracks block position, stride phase and sample
// count, and queues classified work for the mixing back end.
// ----------------------------------------------------------------------------
module flbmh_front import flbmh_pkg::*; #(
    parameter  int BLOCK_BYTES   = BLOCK_BYTES_DEF,
    parameter  int SAMPLE_SLOTS  = SAMPLE_SLOTS_DEF,
    parameter  int SAMPLE_STRIDE = SAMPLE_STRIDE_DEF,
    localparam int POS_W         = pos_width(BLOCK_BYTES),
    localparam int ENTRY_W       = entry_width(POS_W)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    flbmh_item_if.sink         i_item,
    input  logic               i_q_full,
    output logic               o_q_push,
    output logic [ENTRY_W-1:0] o_q_entry
);

    localparam int KEEP = (SAMPLE_SLOTS < OUT_SAMPLES) ? SAMPLE_SLOTS : OUT_SAMPLES;
    localparam int CNT_W = $clog2(KEEP + 1);
    localparam int PH_W  = (SAMPLE_STRIDE > 1) ? $clog2(SAMPLE_STRIDE) : 1;

    typedef struct packed {
        logic [DATA_W-1:0]    data_byte;
        logic                 has_byte;
        logic                 is_end;
        logic [POS_W-1:0]     wr_pos;
        logic [POS_W-1:0]     end_pos;
        logic                 smp_en;
        logic [SMP_IDX_W-1:0] smp_idx;
    } t_entry;

    logic [POS_W-1:0] r_pos;
    logic [PH_W-1:0]  r_phase;
    logic [CNT_W-1:0] r_count;

    logic             accept;
    logic [POS_W-1:0] next_pos;
    logic [PH_W-1:0]  next_phase;
    logic             smp_take;
    t_entry           entry;

    assign i_item.ready = !i_q_full;
    assign accept       = i_item.valid && i_item.ready;

    assign next_pos   = (r_pos == POS_W'(BLOCK_BYTES - 1)) ? '0 : POS_W'(r_pos + 1'b1);
    assign next_phase = (r_phase == PH_W'(SAMPLE_STRIDE - 1)) ? '0 : PH_W'(r_phase + 1'b1);
    assign smp_take   = (r_phase == '0) && (r_count < CNT_W'(KEEP));

    always_comb begin
        entry.data_byte = i_item.data_byte;
        entry.has_byte  = i_item.has_byte;
        entry.is_end    = i_item.end_of_message;
        entry.wr_pos    = r_pos;
        entry.end_pos   = i_item.has_byte ? next_pos : r_pos;
        entry.smp_en    = i_item.has_byte && smp_take;
        entry.smp_idx   = SMP_IDX_W'(r_count);
    end

    assign o_q_push  = accept && (i_item.has_byte || i_item.end_of_message);
    assign o_q_entry = entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_phase <= '0;
            r_count <= '0;
        end else if (accept) begin
            if (i_item.end_of_message) begin
                r_pos   <= '0;
                r_phase <= '0;
                r_count <= '0;
            end else if (i_item.has_byte) begin
                r_pos   <= next_pos;
                r_phase <= next_phase;
                if (smp_take) begin
                    r_count <= CNT_W'(r_count + 1'b1);
                end
            end
        end
    end

endmodule

// File: src/flbmh_queue.sv
// ----------------------------------------------------------------------------
// flbmh_queue
// Small register FIFO between the front end and the mixing back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module flbmh_queue #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 4,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_wr_ptr + 1'b1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_rd_ptr + 1'b1);
            end
            if (do_push && !do_pop) begin
                r_count <= CNT_W'(r_count + 1'b1);
            end else if (do_pop && !do_push) begin
                r_count <= CNT_W'(r_count - 1'b1);
            end
        end
    end

    `ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH), "queue count above depth")

endmodule

// File: src/flbmh_back.sv
// ----------------------------------------------------------------------------
// flbmh_back
// Mixes queued bytes into the four words, replays the tail of a partial
// block from the block store, and sends out the eight digest words.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module flbmh_back import flbmh_pkg::*; #(
    parameter  int BLOCK_BYTES = BLOCK_BYTES_DEF,
    localparam int POS_W       = pos_width(BLOCK_BYTES),
    localparam int ENTRY_W     = entry_width(POS_W)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    output logic               o_q_pop,
    input  logic [ENTRY_W-1:0] i_q_entry,
    flbmh_digest_if.source     o_digest
);

    localparam int RA_W = POS_W + 1;

    localparam logic [1:0] ST_RUN    = 2'd0;
    localparam logic [1:0] ST_REPLAY = 2'd1;
    localparam logic [1:0] ST_EMIT   = 2'd2;

    typedef struct packed {
        logic [DATA_W-1:0]    data_byte;
        logic                 has_byte;
        logic                 is_end;
        logic [POS_W-1:0]     wr_pos;
        logic [POS_W-1:0]     end_pos;
        logic                 smp_en;
        logic [SMP_IDX_W-1:0] smp_idx;
    } t_entry;

    logic [1:0]                        r_state;
    t_words                            r_words;
    logic [BLOCK_BYTES-1:0]            r_blk_vld;
    logic [3:0][7:0][DATA_W-1:0]       r_smp;
    logic [RA_W-1:0]                   r_rep_addr;
    logic                              r_rd_live;
    logic                              r_rd_vld;
    logic [2:0]                        r_idx;
    logic                              r_out_vld;
    logic [DIGEST_W-1:0]               r_out_word;
    logic                              r_out_last;

    t_entry            entry;
    logic              pop;
    logic              rep_more;
    logic              rd_en;
    logic [POS_W-1:0]  rd_addr;
    logic [DATA_W-1:0] rd_data;
    logic              wr_en;
    logic              mix_en;
    logic [DATA_W-1:0] mix_in;
    t_words            mixed;
    logic              emit_load;
    logic              emit_last;
    logic [DIGEST_W-1:0] out_sel;

    assign entry    = i_q_entry;
    assign pop      = (r_state == ST_RUN) && !i_q_empty;
    assign o_q_pop  = pop;
    assign wr_en    = pop && entry.has_byte;
    assign rep_more = r_rep_addr < RA_W'(BLOCK_BYTES);
    assign rd_en    = (r_state == ST_REPLAY) && rep_more;
    assign rd_addr  = r_rep_addr[POS_W-1:0];

    flbmh_ram #(
        .WIDTH (DATA_W),
        .DEPTH (BLOCK_BYTES)
    ) u_block_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (entry.wr_pos),
        .i_wr_data (entry.data_byte),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign mix_en = wr_en || ((r_state == ST_REPLAY) && r_rd_live);
    assign mix_in = (r_state == ST_RUN) ? entry.data_byte
                  : (r_rd_vld ? rd_data : '0);
    assign mixed  = mix_round(r_words, mix_in);

    assign emit_load = (r_state == ST_EMIT) && (!r_out_vld || o_digest.ready);
    assign emit_last = emit_load && (r_idx == 3'(OUT_WORDS - 1));
    assign out_sel   = r_idx[2] ? r_smp[r_idx[1:0]] : r_words[r_idx[1:0]];

    assign o_digest.valid       = r_out_vld;
    assign o_digest.digest_word = r_out_word;
    assign o_digest.last_word   = r_out_last;

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_vld <= r_blk_vld[rd_addr];
        end
        if (emit_load) begin
            r_out_word <= out_sel;
            r_out_last <= emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_RUN;
            r_words    <= SEEDS;
            r_blk_vld  <= '0;
            r_smp      <= '0;
            r_rep_addr <= '0;
            r_rd_live  <= 1'b0;
            r_idx      <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_rd_live <= rd_en;
            if (mix_en) begin
                r_words <= mixed;
            end
            if (emit_load) begin
                r_out_vld <= 1'b1;
            end else if (o_digest.ready) begin
                r_out_vld <= 1'b0;
            end

            unique case (r_state)
                ST_RUN: begin
                    if (pop) begin
                        if (entry.has_byte) begin
                            r_blk_vld[entry.wr_pos] <= 1'b1;
                        end
                        if (entry.smp_en) begin
                            r_smp[entry.smp_idx[4:3]][3'd7 - entry.smp_idx[2:0]] <=
                                entry.data_byte;
                        end
                        if (entry.is_end) begin
                            if (entry.end_pos != '0) begin
                                r_rep_addr <= {1'b0, entry.end_pos};
                                r_state    <= ST_REPLAY;
                            end else begin
                                r_state <= ST_EMIT;
                            end
                        end
                    end
                end
                ST_REPLAY: begin
                    if (rep_more) begin
                        r_rep_addr <= RA_W'(r_rep_addr + 1'b1);
                    end else if (!r_rd_live) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (emit_load) begin
                        if (emit_last) begin
                            r_idx     <= '0;
                            r_words   <= SEEDS;
                            r_blk_vld <= '0;
                            r_smp     <= '0;
                            r_state   <= ST_RUN;
                        end else begin
                            r_idx <= 3'(r_idx + 1'b1);
                        end
                    end
                end
                default: begin
                    r_state <= ST_RUN;
                end
            endcase
        end
    end

    `ASSERT_NEXT(a_digest_clears, i_clk, i_rst_n, emit_last, (r_state == ST_RUN) && (r_words == SEEDS) && (r_blk_vld == '0), "state not cleared after digest")
    `ASSERT_IMPL(a_read_in_replay, i_clk, i_rst_n, r_rd_live, r_state == ST_REPLAY, "block read outside replay")

endmodule

// File: src/four_lane_byte_mix_hash_top.sv
// ----------------------------------------------------------------------------
// four_lane_byte_mix_hash_top
// Byte-serial four word mixing hash with stride sampling.
//
// Usage:
//   i_item carries one message item per request: data_byte, has_byte and
//   end_of_message. An item with has_byte low and end_of_message low is
//   dropped. o_digest carries eight digest words per message, the eighth
//   flagged by last_word: mix words 0..3, then four words of samples.
//   Throughput: one byte per cycle outside replay and digest output, set by
//   the single back end mixing round. A four entry queue sits between item
//   intake and mixing; each byte is mixed when the back end pops it. On the
//   end item, a partial block replays its tail from the block RAM (one byte
//   per cycle), then the eight words leave at one per cycle while the
//   receiver is ready. Intake continues into the queue until it fills.
//   Reset puts the seeds in the mix words and clears the block valid bits,
//   samples and counters; the block RAM needs no clearing pass.
//   A stalled receiver holds the current digest word in the output register;
//   the back end then waits and the queue backs up to i_item.ready.
// ----------------------------------------------------------------------------
module four_lane_byte_mix_hash_top import flbmh_pkg::*; #(
    parameter int BLOCK_BYTES   = BLOCK_BYTES_DEF,
    parameter int SAMPLE_SLOTS  = SAMPLE_SLOTS_DEF,
    parameter int SAMPLE_STRIDE = SAMPLE_STRIDE_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    flbmh_item_if.sink     i_item,
    flbmh_digest_if.source o_digest
);

    localparam int POS_W   = pos_width(BLOCK_BYTES);
    localparam int ENTRY_W = entry_width(POS_W);

    logic               q_push;
    logic [ENTRY_W-1:0] q_in;
    logic               q_full;
    logic               q_pop;
    logic [ENTRY_W-1:0] q_out;
    logic               q_empty;

    flbmh_front #(
        .BLOCK_BYTES   (BLOCK_BYTES),
        .SAMPLE_SLOTS  (SAMPLE_SLOTS),
        .SAMPLE_STRIDE (SAMPLE_STRIDE)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_item),
        .i_q_full  (q_full),
        .o_q_push  (q_push),
        .o_q_entry (q_in)
    );

    flbmh_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    flbmh_back #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .i_q_entry (q_out),
        .o_digest  (o_digest)
    );

endmodule
